### hdl/jqst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jqst_pkg
// Types and constants shared by the job queue state tracker.
// ----------------------------------------------------------------------------
package jqst_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int ID_BITS_DEF      = 16;
    localparam int PAYLOAD_BITS_DEF = 16;

    localparam logic [2:0] CMD_ENQUEUE    = 3'd0;
    localparam logic [2:0] CMD_SERVE      = 3'd1;
    localparam logic [2:0] CMD_DONE       = 3'd2;
    localparam logic [2:0] CMD_PAUSE      = 3'd3;
    localparam logic [2:0] CMD_RESUME     = 3'd4;
    localparam logic [2:0] CMD_CANCEL     = 3'd5;
    localparam logic [2:0] CMD_CANCEL_ALL = 3'd6;

    localparam logic [2:0] ST_PENDING   = 3'd0;
    localparam logic [2:0] ST_PLAYING   = 3'd1;
    localparam logic [2:0] ST_PAUSED    = 3'd2;
    localparam logic [2:0] ST_DONE      = 3'd3;
    localparam logic [2:0] ST_CANCELLED = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] target_id;
        logic [15:0] payload;
    } in_item_t;

    typedef struct packed {
        logic        event_valid;
        logic [15:0] event_id;
        logic [2:0]  event_state;
        logic        accepted;
        logic [15:0] served_payload;
        logic [4:0]  occupancy;
        logic        playing_flag;
        logic        last;
    } out_item_t;

endpackage
`default_nettype wire

### hdl/jqst_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jqst_cell
// One table slot. Holds id, payload and state; shifts toward the head.
// ----------------------------------------------------------------------------
module jqst_cell #(
    parameter int ID_BITS      = 16,
    parameter int PAYLOAD_BITS = 16
) (
    input  wire                    aclk,
    input  wire                    shift_en,
    input  wire [ID_BITS-1:0]      nb_id,
    input  wire [PAYLOAD_BITS-1:0] nb_pay,
    input  wire [2:0]              nb_state,
    input  wire                    wr_en,
    input  wire [ID_BITS-1:0]      wr_id,
    input  wire [PAYLOAD_BITS-1:0] wr_pay,
    input  wire                    st_en,
    input  wire [2:0]              st_val,
    output logic [ID_BITS-1:0]     id_q,
    output logic [PAYLOAD_BITS-1:0] pay_q,
    output logic [2:0]             state_q
);
    logic [ID_BITS-1:0]      id_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [2:0]              state_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            id_reg    <= nb_id;
            pay_reg   <= nb_pay;
            state_reg <= nb_state;
        end else begin
            if (wr_en) begin
                id_reg  <= wr_id;
                pay_reg <= wr_pay;
            end
            if (st_en) state_reg <= st_val;
        end
    end

    assign id_q    = id_reg;
    assign pay_q   = pay_reg;
    assign state_q = state_reg;
endmodule
`default_nettype wire

### hdl/job_queue_state_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// job_queue_state_tracker_core
// Ordered job table built as a row of cells, oldest entry in cell 0.
// ----------------------------------------------------------------------------
// Usage: commands enter on s_valid/s_ready with a jqst_pkg::in_item_t
// payload; results leave on m_valid/m_ready as jqst_pkg::out_item_t, one or
// more per command, the final one flagged by last.
// A command runs in phases: a scan that walks the cells one per cycle (a
// cancel all scan halts at an active entry while the output register still
// holds an unaccepted result), a drain phase for enqueue and mark done in
// which enqueue writes the new entry and mark done shifts the row one cell
// per cycle toward cell 0 while the head is done or cancelled, a playing
// flag sweep over the held cells, and a state that loads the output register.
// Cancel all issues one result per active entry (an empty one if none); each
// is held until the next active entry is found, and the last leaves flagged.
// Commands are taken one at a time; s_ready is high only while idle, and a
// new command may be taken while the previous final result still waits.
// A stalled receiver holds the current result in the output register, halts
// a cancel all scan and keeps a command waiting in S_OUT. Reset empties the
// table and clears the id counter; cell contents are not cleared.
// ----------------------------------------------------------------------------
module job_queue_state_tracker_core #(
    parameter int DEPTH        = jqst_pkg::DEPTH_DEF,
    parameter int ID_BITS      = jqst_pkg::ID_BITS_DEF,
    parameter int PAYLOAD_BITS = jqst_pkg::PAYLOAD_BITS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  jqst_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output jqst_pkg::out_item_t m_data
);
    import jqst_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_FLAG  = 5'b01000,
        S_OUT   = 5'b10000
    } fsm_t;

    fsm_t state_reg, state_next;
    in_item_t cmd_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [ID_BITS-1:0] idc_reg, idc_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic found_reg, found_next;
    logic any_reg, any_next;
    logic play_reg, play_next;
    logic m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;
    out_item_t res_reg, res_next;

    logic [ID_BITS-1:0]      c_id [DEPTH];
    logic [PAYLOAD_BITS-1:0] c_pay [DEPTH];
    logic [2:0]              c_st [DEPTH];
    logic shift_en, wr_en, st_en;
    logic [2:0] st_val;
    logic [IW-1:0] ptr_idx;
    logic [ID_BITS-1:0] tid_ext;
    logic [PAYLOAD_BITS-1:0] pay_ext;
    logic id_match, tid_ok;
    logic [2:0] cur_st;
    logic out_free;

    assign ptr_idx = ptr_reg[IW-1:0];
    assign cur_st  = c_st[ptr_idx];
    assign out_free = !m_valid_reg || m_ready;

    generate
        if (ID_BITS >= 16) begin : g_wide
            assign tid_ext = ID_BITS'(cmd_reg.target_id);
            assign tid_ok  = 1'b1;
        end else begin : g_narrow
            assign tid_ext = cmd_reg.target_id[ID_BITS-1:0];
            assign tid_ok  = (cmd_reg.target_id >> ID_BITS) == '0;
        end
        if (PAYLOAD_BITS >= 16) begin : g_pay_wide
            assign pay_ext = PAYLOAD_BITS'(cmd_reg.payload);
        end else begin : g_pay_narrow
            assign pay_ext = cmd_reg.payload[PAYLOAD_BITS-1:0];
        end
    endgenerate
    assign id_match = tid_ok && (c_id[ptr_idx] == tid_ext);

    function automatic logic [15:0] id16(input logic [ID_BITS-1:0] v);
        logic [ID_BITS+15:0] t;
        t = {16'd0, v};
        return t[15:0];
    endfunction

    function automatic logic [15:0] pay16(input logic [PAYLOAD_BITS-1:0] v);
        logic [PAYLOAD_BITS+15:0] t;
        t = {16'd0, v};
        return t[15:0];
    endfunction

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [ID_BITS-1:0]      nid;
            logic [PAYLOAD_BITS-1:0] npay;
            logic [2:0]              nst;
            if (g == DEPTH - 1) begin : g_end
                assign nid = '0;
                assign npay = '0;
                assign nst = ST_DONE;
            end else begin : g_mid
                assign nid = c_id[g+1];
                assign npay = c_pay[g+1];
                assign nst = c_st[g+1];
            end
            jqst_cell #(.ID_BITS(ID_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
                .aclk    (aclk),
                .shift_en(shift_en),
                .nb_id   (nid),
                .nb_pay  (npay),
                .nb_state(nst),
                .wr_en   (wr_en && (ptr_idx == IW'(g))),
                .wr_id   (idc_reg),
                .wr_pay  (pay_ext),
                .st_en   (st_en && (ptr_idx == IW'(g))),
                .st_val  (st_val),
                .id_q    (c_id[g]),
                .pay_q   (c_pay[g]),
                .state_q (c_st[g])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idc_next     = idc_reg;
        ptr_next     = ptr_reg;
        found_next   = found_reg;
        any_next     = any_reg;
        play_next    = play_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        res_next     = res_reg;
        shift_en = 1'b0;
        wr_en    = 1'b0;
        st_en    = 1'b0;
        st_val   = ST_PENDING;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                ptr_next   = '0;
                found_next = 1'b0;
                any_next   = 1'b0;
                play_next  = 1'b0;
                res_next   = '0;
                if (s_valid) state_next = S_SCAN;
            end
            S_SCAN: begin
                priority if (cmd_reg.command == CMD_ENQUEUE) begin
                    if (count_reg < CW'(DEPTH)) begin
                        ptr_next = count_reg;
                        wr_en = 1'b0;
                        res_next.event_valid = 1'b1;
                        res_next.event_id = id16(idc_reg);
                        res_next.accepted = 1'b1;
                        found_next = 1'b1;
                    end
                    state_next = S_DRAIN;
                end else if (cmd_reg.command == CMD_CANCEL_ALL) begin
                    if (ptr_reg >= count_reg) begin
                        // staged event, or an empty result, leaves from S_OUT
                        count_next = '0;
                        ptr_next = '0;
                        state_next = S_FLAG;
                    end else if (cur_st <= ST_PAUSED) begin
                        // staged event is released once the next one is known
                        if (!any_reg || out_free) begin
                            st_en = 1'b1;
                            st_val = ST_CANCELLED;
                            if (any_reg) begin
                                m_valid_next = 1'b1;
                                m_data_next = res_reg;
                            end
                            res_next = '0;
                            res_next.event_valid = 1'b1;
                            res_next.event_id = id16(c_id[ptr_idx]);
                            res_next.event_state = ST_CANCELLED;
                            any_next = 1'b1;
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end else if (ptr_reg >= count_reg || found_reg) begin
                    ptr_next = '0;
                    state_next = (cmd_reg.command == CMD_DONE) ? S_DRAIN : S_FLAG;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                    unique case (cmd_reg.command)
                        CMD_SERVE: if (cur_st == ST_PENDING) begin
                            st_en = 1'b1; st_val = ST_PLAYING; found_next = 1'b1;
                            res_next.event_valid = 1'b1;
                            res_next.event_id = id16(c_id[ptr_idx]);
                            res_next.event_state = ST_PLAYING;
                            res_next.accepted = 1'b1;
                            res_next.served_payload = pay16(c_pay[ptr_idx]);
                        end
                        CMD_DONE, CMD_CANCEL: if (id_match) begin
                            st_en = 1'b1; found_next = 1'b1;
                            st_val = (cmd_reg.command == CMD_DONE) ? ST_DONE : ST_CANCELLED;
                            res_next.event_valid = 1'b1;
                            res_next.event_id = cmd_reg.target_id;
                            res_next.event_state = st_val;
                        end
                        CMD_PAUSE: if (id_match && cur_st == ST_PLAYING) begin
                            st_en = 1'b1; st_val = ST_PAUSED; found_next = 1'b1;
                            res_next.event_valid = 1'b1;
                            res_next.event_id = cmd_reg.target_id;
                            res_next.event_state = ST_PAUSED;
                        end
                        CMD_RESUME: if (id_match && cur_st == ST_PAUSED) begin
                            st_en = 1'b1; st_val = ST_PLAYING; found_next = 1'b1;
                            res_next.event_valid = 1'b1;
                            res_next.event_id = cmd_reg.target_id;
                            res_next.event_state = ST_PLAYING;
                        end
                        default: begin
                            ptr_next = ptr_reg;
                            state_next = S_FLAG;
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                if (cmd_reg.command == CMD_ENQUEUE) begin
                    if (found_reg) begin
                        wr_en = 1'b1;
                        st_en = 1'b1;
                        st_val = ST_PENDING;
                        count_next = count_reg + 1'b1;
                        idc_next = idc_reg + 1'b1;
                    end
                    ptr_next = '0;
                    state_next = S_FLAG;
                end else if (count_reg != '0 &&
                             (c_st[0] == ST_DONE || c_st[0] == ST_CANCELLED)) begin
                    shift_en = 1'b1;
                    count_next = count_reg - 1'b1;
                end else begin
                    ptr_next = '0;
                    state_next = S_FLAG;
                end
            end
            S_FLAG: begin
                if (ptr_reg >= count_reg) begin
                    state_next = S_OUT;
                end else begin
                    if (cur_st == ST_PLAYING) play_next = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next = res_reg;
                    m_data_next.occupancy = 5'(count_reg);
                    m_data_next.playing_flag = play_reg;
                    m_data_next.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idc_reg     <= idc_next;
            m_valid_reg <= m_valid_next;
        end
        ptr_reg    <= ptr_next;
        found_reg  <= found_next;
        any_reg    <= any_next;
        play_reg   <= play_next;
        m_data_reg <= m_data_next;
        res_reg    <= res_next;
        if (state_reg == S_IDLE && s_valid) cmd_reg <= s_data;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign s_ready = (state_reg == S_IDLE);

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("occupancy above depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_SCAN)
        else $error("command not started");
    assert property (@(posedge aclk) disable iff (!aresetn)
        shift_en |-> state_reg == S_DRAIN)
        else $error("shift outside drain");
endmodule
`default_nettype wire

### tb/job_queue_state_tracker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_queue_state_tracker_core_test
// Drives command transactions into the job table and checks every result
// against a behavioral copy of the table kept in the testbench.
// ----------------------------------------------------------------------------
module job_queue_state_tracker_core_test;
    import jqst_pkg::*;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 4000;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    job_queue_state_tracker_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // table copy, oldest first
    logic [15:0] tbl_id [$];
    logic [15:0] tbl_pay [$];
    logic [2:0] tbl_st [$];
    logic [15:0] next_id;
    out_item_t pending_results [$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int find_entry(input logic [15:0] id, input bit need_st,
                                      input logic [2:0] st);
        for (int i = 0; i < tbl_id.size(); i++)
            if (tbl_id[i] == id && (!need_st || tbl_st[i] == st)) return i;
        return -1;
    endfunction

    task automatic predict_command(input in_item_t it);
        out_item_t r [$];
        out_item_t o;
        int k;
        bit play;
        o = '0;
        case (it.command)
            CMD_ENQUEUE: begin
                if (tbl_id.size() < DEPTH) begin
                    tbl_id = {tbl_id, next_id};
                    tbl_pay = {tbl_pay, it.payload};
                    tbl_st = {tbl_st, ST_PENDING};
                    o.event_valid = 1'b1; o.event_id = next_id;
                    o.event_state = ST_PENDING; o.accepted = 1'b1;
                    next_id++;
                end
                r = {r, o};
            end
            CMD_SERVE: begin
                k = -1;
                for (int i = 0; i < tbl_st.size(); i++)
                    if (k < 0 && tbl_st[i] == ST_PENDING) k = i;
                if (k >= 0) begin
                    tbl_st[k] = ST_PLAYING;
                    o.event_valid = 1'b1; o.event_id = tbl_id[k];
                    o.event_state = ST_PLAYING; o.accepted = 1'b1;
                    o.served_payload = tbl_pay[k];
                end
                r = {r, o};
            end
            CMD_DONE, CMD_CANCEL: begin
                k = find_entry(it.target_id, 1'b0, ST_PENDING);
                if (k >= 0) begin
                    tbl_st[k] = (it.command == CMD_DONE) ? ST_DONE : ST_CANCELLED;
                    o.event_valid = 1'b1; o.event_id = it.target_id;
                    o.event_state = tbl_st[k];
                end
                r = {r, o};
                if (it.command == CMD_DONE)
                    while (tbl_st.size() > 0 &&
                           (tbl_st[0] == ST_DONE || tbl_st[0] == ST_CANCELLED)) begin
                        void'(tbl_id.pop_front());
                        void'(tbl_pay.pop_front());
                        void'(tbl_st.pop_front());
                    end
            end
            CMD_PAUSE, CMD_RESUME: begin
                k = find_entry(it.target_id, 1'b1,
                               (it.command == CMD_PAUSE) ? ST_PLAYING : ST_PAUSED);
                if (k >= 0) begin
                    tbl_st[k] = (it.command == CMD_PAUSE) ? ST_PAUSED : ST_PLAYING;
                    o.event_valid = 1'b1; o.event_id = it.target_id;
                    o.event_state = tbl_st[k];
                end
                r = {r, o};
            end
            CMD_CANCEL_ALL: begin
                for (int i = 0; i < tbl_st.size(); i++)
                    if (tbl_st[i] <= ST_PAUSED) begin
                        o = '0;
                        o.event_valid = 1'b1; o.event_id = tbl_id[i];
                        o.event_state = ST_CANCELLED;
                        r = {r, o};
                    end
                if (r.size() == 0) begin
                    o = '0;
                    r = {r, o};
                end
                tbl_id.delete(); tbl_pay.delete(); tbl_st.delete();
            end
            default: r = {r, o};
        endcase
        play = 1'b0;
        foreach (tbl_st[i]) if (tbl_st[i] == ST_PLAYING) play = 1'b1;
        foreach (r[i]) begin
            r[i].occupancy = 5'(tbl_id.size());
            r[i].playing_flag = play;
            r[i].last = (i == r.size() - 1);
            pending_results = {pending_results, r[i]};
        end
    endtask

    task automatic send_command(input logic [2:0] cmd, input logic [15:0] tid,
                                input logic [15:0] pay);
        in_item_t it;
        bit idle;
        it.command = cmd; it.target_id = tid; it.payload = pay;
        idle = ($urandom_range(99) < send_idle_pct);
        if (idle) s_valid <= 1'b0;
        while (idle) begin
            @(posedge aclk);
            idle = ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_command(it);
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                out_item_t e;
                e = pending_results.pop_front();
                if (m_data.event_valid !== e.event_valid)
                    report_mismatch($sformatf("event_valid %b exp %b",
                                    m_data.event_valid, e.event_valid));
                if (m_data.event_id !== e.event_id)
                    report_mismatch($sformatf("event_id %h exp %h", m_data.event_id, e.event_id));
                if (m_data.event_state !== e.event_state)
                    report_mismatch($sformatf("event_state %0d exp %0d",
                                    m_data.event_state, e.event_state));
                if (m_data.accepted !== e.accepted)
                    report_mismatch($sformatf("accepted %b exp %b", m_data.accepted, e.accepted));
                if (m_data.served_payload !== e.served_payload)
                    report_mismatch($sformatf("served_payload %h exp %h",
                                    m_data.served_payload, e.served_payload));
                if (m_data.occupancy !== e.occupancy)
                    report_mismatch($sformatf("occupancy %0d exp %0d",
                                    m_data.occupancy, e.occupancy));
                if (m_data.playing_flag !== e.playing_flag)
                    report_mismatch($sformatf("playing_flag %b exp %b",
                                    m_data.playing_flag, e.playing_flag));
                if (m_data.last !== e.last)
                    report_mismatch($sformatf("last %b exp %b", m_data.last, e.last));
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("job_queue_state_tracker_core verification failed");
            $finish;
        end
    end

    function automatic logic [15:0] pick_id();
        if (tbl_id.size() > 0 && $urandom_range(9) < 8)
            return tbl_id[$urandom_range(tbl_id.size() - 1)];
        return 16'($urandom);
    endfunction

    task automatic test_directed();
        send_command(CMD_SERVE, 16'h0000, 16'hFFFF);        // empty table
        send_command(CMD_CANCEL_ALL, 16'h0000, 16'h0000);   // nothing active
        send_command(CMD_DONE, 16'hFFFF, 16'h0000);         // no match
        for (int i = 0; i < DEPTH; i++)
            send_command(CMD_ENQUEUE, 16'hFFFF, (i == 0) ? 16'hFFFF : 16'(i));
        send_command(CMD_ENQUEUE, 16'h0000, 16'h1234);      // full, rejected
        send_command(CMD_SERVE, 16'hFFFF, 16'h0000);
        send_command(CMD_PAUSE, 16'h0000, 16'h0000);
        send_command(CMD_PAUSE, 16'h0000, 16'h0000);        // already paused
        send_command(CMD_RESUME, 16'h0000, 16'h0000);
        send_command(CMD_CANCEL, 16'h0001, 16'h0000);       // stays held
        send_command(CMD_DONE, 16'h0000, 16'h0000);         // drains two
        send_command(CMD_DONE, 16'h0000, 16'h0000);         // already gone
        send_command(CMD_UNUSED, 16'hFFFF, 16'hFFFF);       // unused code
        send_command(CMD_CANCEL_ALL, 16'h0000, 16'h0000);
    endtask

    task automatic test_random(input int n);
        logic [2:0] cmd;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4: cmd = CMD_ENQUEUE;
                5, 6, 7: cmd = CMD_SERVE;
                8, 9, 10: cmd = CMD_DONE;
                11, 12: cmd = CMD_PAUSE;
                13, 14: cmd = CMD_RESUME;
                15, 16: cmd = CMD_CANCEL;
                17: cmd = ($urandom_range(3) == 0) ? CMD_CANCEL_ALL : CMD_ENQUEUE;
                default: cmd = 3'($urandom_range(7));
            endcase
            send_command(cmd, pick_id(), 16'($urandom));
        end
    endtask

    // enqueue then mark done on the head entry, so the head keeps draining
    task automatic test_id_wrap();
        for (int i = 0; i < 8; i++) begin
            send_command(CMD_ENQUEUE, 16'h0000, 16'($urandom));
            send_command(CMD_DONE, tbl_id[0], 16'h0000);
        end
    endtask

    initial begin
        next_id = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 10; recv_idle_pct = 58;
        test_directed();
        test_random(80);
        send_idle_pct = 58; recv_idle_pct = 10;
        test_random(70);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(65);
        test_id_wrap();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("job_queue_state_tracker_core verification clean");
        else
            $display("job_queue_state_tracker_core verification failed");
        $finish;
    end
endmodule
